[rtl/core/bfsp_pkg.sv]
// Shared types and constants for the shortest-path block.
`default_nettype none

package bfsp_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;
    localparam int KEY_W         = 32;
    localparam int WEIGHT_W      = 32;
    localparam int OUT_DIST_W    = 39;

    // Saturation limit of the reported distance.
    localparam longint DIST_LIMIT = 64'sd137438953472;

    typedef enum logic [1:0] {
        OP_ADD_NODE,
        OP_ADD_EDGE,
        OP_SOLVE,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_UNREACHED,
        ST_NEG_CYCLE,
        ST_UNKNOWN_KEY
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CMP,
        S_LK_END,
        S_INIT,
        S_SRC,
        S_E_RD,
        S_D_RD,
        S_RELAX,
        S_DST_RD,
        S_DST_OUT
    } state_t;

endpackage

`default_nettype wire

[rtl/core/bfsp_relax_unit.sv]
// Shared add and compare unit that tests one edge relaxation.
`default_nettype none

module bfsp_relax_unit
    import bfsp_pkg::*;
#(
    parameter int DW = 47
)
(
    input  wire logic                       src_reached,
    input  wire logic signed [DW-1:0]       src_dist,
    input  wire logic                       dst_reached,
    input  wire logic signed [DW-1:0]       dst_dist,
    input  wire logic signed [WEIGHT_W-1:0] weight,
    output logic signed [DW-1:0]            cand,
    output logic                            improve
);

    always_comb
    begin
        cand    = src_dist + DW'(weight);
        improve = src_reached && (!dst_reached || (cand < dst_dist));
    end

endmodule

`default_nettype wire

[rtl/core/bellman_ford_shortest_path.sv]
// Top level: graph store, sequencer and result register of the shortest-path block.
//
// Usage: present op, first_key, second_key and weight with start high; the item is
// taken at a rising edge where start is high and busy is low. Add node and clear
// finish without leaving idle, so busy stays low. Add edge scans the node key memory,
// a read state and a compare state per node, to map both keys to indices, and holds
// busy until the scan ends. Solve scans the keys the same way; if both are found it
// clears the node_count working distances, then runs up to node_count passes
// (node_count-1 relaxation passes and one negative cycle check) over the stored edges,
// with an edge read, a distance read and a relax state per edge on the single add and
// compare unit, then reads the destination. One result comes out per solve, on status
// and distance for exactly one cycle with done high; the receiver cannot stall it.
// Load and clear items give no result.
// Reset empties the graph (node and edge counts to zero) and returns to idle; the
// stored keys, edges and distances are not cleared and are never read before written.
`default_nettype none

module bellman_ford_shortest_path
    import bfsp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    op,
    input  wire logic signed [KEY_W-1:0]       first_key,
    input  wire logic signed [KEY_W-1:0]       second_key,
    input  wire logic signed [WEIGHT_W-1:0]    weight,
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [OUT_DIST_W-1:0]       distance
);

    localparam int NIW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    // Wide enough for any walk the passes can build.
    localparam int DW  = NIW + ECW + WEIGHT_W;
    localparam int SW  = (DW > OUT_DIST_W + 1) ? DW : OUT_DIST_W + 1;

    // Memories
    logic [KEY_W-1:0]      key_mem   [MAX_NODES];
    logic [NIW-1:0]        efrom_mem [MAX_EDGES];
    logic [NIW-1:0]        eto_mem   [MAX_EDGES];
    logic [WEIGHT_W-1:0]   ew_mem    [MAX_EDGES];
    logic [DW:0]           dist_mem  [MAX_NODES];

    logic [KEY_W-1:0]      key_rd_reg;
    logic [NIW-1:0]        efrom_rd_reg;
    logic [NIW-1:0]        eto_rd_reg;
    logic [WEIGHT_W-1:0]   ew_rd_reg;
    logic [DW:0]           ds_rd_reg;
    logic [DW:0]           de_rd_reg;

    // Control and working registers
    state_t                state_reg, state_next;
    logic [NCW-1:0]        node_count_reg, node_count_next;
    logic [ECW-1:0]        edge_count_reg, edge_count_next;
    logic [NIW-1:0]        scan_reg, scan_next;
    logic [EIW-1:0]        edge_idx_reg, edge_idx_next;
    logic [NCW-1:0]        pass_reg, pass_next;
    op_t                   op_reg, op_next;
    logic [KEY_W-1:0]      k1_reg, k1_next;
    logic [KEY_W-1:0]      k2_reg, k2_next;
    logic [WEIGHT_W-1:0]   w_reg, w_next;
    logic                  f1_reg, f1_next;
    logic                  f2_reg, f2_next;
    logic [NIW-1:0]        i1_reg, i1_next;
    logic [NIW-1:0]        i2_reg, i2_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic [OUT_DIST_W-1:0] distance_reg, distance_next;

    // Memory write controls
    logic                  key_we;
    logic                  edge_we;
    logic                  dist_we;
    logic [NIW-1:0]        dist_wa;
    logic [DW:0]           dist_wd;
    logic [NIW-1:0]        dist_ra;

    // Relax unit
    logic signed [DW-1:0]  cand;
    logic                  improve;

    logic                  k1_hit, k2_hit;
    logic                  lk_last, init_last, edge_last, check_pass;
    logic signed [SW-1:0]  dst_ext;
    logic signed [SW-1:0]  dst_sat;

    bfsp_relax_unit #(
        .DW (DW)
    ) u_relax (
        .src_reached (ds_rd_reg[DW]),
        .src_dist    (signed'(ds_rd_reg[DW-1:0])),
        .dst_reached (de_rd_reg[DW]),
        .dst_dist    (signed'(de_rd_reg[DW-1:0])),
        .weight      (signed'(ew_rd_reg)),
        .cand        (cand),
        .improve     (improve)
    );

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign distance = distance_reg;

    assign k1_hit     = (key_rd_reg == k1_reg);
    assign k2_hit     = (key_rd_reg == k2_reg);
    assign lk_last    = ((NCW'(scan_reg) + NCW'(1)) == node_count_reg);
    assign init_last  = lk_last;
    assign edge_last  = ((ECW'(edge_idx_reg) + ECW'(1)) == edge_count_reg);
    assign check_pass = (pass_reg == node_count_reg);
    assign dist_ra    = (state_reg == S_DST_RD) ? i2_reg : efrom_rd_reg;

    always_comb
    begin
        dst_ext = SW'(signed'(ds_rd_reg[DW-1:0]));
        if (dst_ext > SW'(DIST_LIMIT))
        begin
            dst_sat = SW'(DIST_LIMIT);
        end
        else if (dst_ext < -SW'(DIST_LIMIT))
        begin
            dst_sat = -SW'(DIST_LIMIT);
        end
        else
        begin
            dst_sat = dst_ext;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op_t'(op) == OP_ADD_EDGE || op_t'(op) == OP_SOLVE)
                    begin
                        state_next = (node_count_reg == '0) ? S_LK_END : S_LK_RD;
                    end
                end
            end
            S_LK_RD:
            begin
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                if (lk_last || ((f1_reg || k1_hit) && (f2_reg || k2_hit)))
                begin
                    state_next = S_LK_END;
                end
                else
                begin
                    state_next = S_LK_RD;
                end
            end
            S_LK_END:
            begin
                if (op_reg == OP_SOLVE && f1_reg && f2_reg)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_INIT:
            begin
                if (init_last)
                begin
                    state_next = S_SRC;
                end
            end
            S_SRC:
            begin
                state_next = (edge_count_reg == '0) ? S_DST_RD : S_E_RD;
            end
            S_E_RD:
            begin
                state_next = S_D_RD;
            end
            S_D_RD:
            begin
                state_next = S_RELAX;
            end
            S_RELAX:
            begin
                if (check_pass && improve)
                begin
                    state_next = S_IDLE;
                end
                else if (check_pass && edge_last)
                begin
                    state_next = S_DST_RD;
                end
                else
                begin
                    state_next = S_E_RD;
                end
            end
            S_DST_RD:
            begin
                state_next = S_DST_OUT;
            end
            S_DST_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        node_count_next = node_count_reg;
        edge_count_next = edge_count_reg;
        scan_next       = scan_reg;
        edge_idx_next   = edge_idx_reg;
        pass_next       = pass_reg;
        op_next         = op_reg;
        k1_next         = k1_reg;
        k2_next         = k2_reg;
        w_next          = w_reg;
        f1_next         = f1_reg;
        f2_next         = f2_reg;
        i1_next         = i1_reg;
        i2_next         = i2_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        distance_next   = distance_reg;
        key_we          = 1'b0;
        edge_we         = 1'b0;
        dist_we         = 1'b0;
        dist_wa         = scan_reg;
        dist_wd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = op_t'(op);
                    k1_next   = first_key;
                    k2_next   = second_key;
                    w_next    = weight;
                    scan_next = '0;
                    f1_next   = 1'b0;
                    f2_next   = 1'b0;
                    case (op_t'(op))
                        OP_ADD_NODE:
                        begin
                            if (node_count_reg < NCW'(MAX_NODES))
                            begin
                                key_we          = 1'b1;
                                node_count_next = node_count_reg + NCW'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            node_count_next = '0;
                            edge_count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LK_CMP:
            begin
                // Keep the first match only.
                if (!f1_reg && k1_hit)
                begin
                    f1_next = 1'b1;
                    i1_next = scan_reg;
                end
                if (!f2_reg && k2_hit)
                begin
                    f2_next = 1'b1;
                    i2_next = scan_reg;
                end
                scan_next = scan_reg + NIW'(1);
            end
            S_LK_END:
            begin
                scan_next = '0;
                if (op_reg == OP_ADD_EDGE)
                begin
                    if (f1_reg && f2_reg && edge_count_reg < ECW'(MAX_EDGES))
                    begin
                        edge_we         = 1'b1;
                        edge_count_next = edge_count_reg + ECW'(1);
                    end
                end
                else if (!(f1_reg && f2_reg))
                begin
                    done_next     = 1'b1;
                    status_next   = ST_UNKNOWN_KEY;
                    distance_next = '0;
                end
            end
            S_INIT:
            begin
                dist_we   = 1'b1;
                dist_wa   = scan_reg;
                dist_wd   = '0;
                scan_next = scan_reg + NIW'(1);
            end
            S_SRC:
            begin
                dist_we       = 1'b1;
                dist_wa       = i1_reg;
                dist_wd       = {1'b1, {DW{1'b0}}};
                pass_next     = NCW'(1);
                edge_idx_next = '0;
            end
            S_RELAX:
            begin
                if (check_pass)
                begin
                    if (improve)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_NEG_CYCLE;
                        distance_next = '0;
                    end
                end
                else if (improve)
                begin
                    dist_we = 1'b1;
                    dist_wa = eto_rd_reg;
                    dist_wd = {1'b1, cand};
                end
                if (edge_last)
                begin
                    edge_idx_next = '0;
                    pass_next     = pass_reg + NCW'(1);
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + EIW'(1);
                end
            end
            S_DST_OUT:
            begin
                done_next = 1'b1;
                if (!ds_rd_reg[DW])
                begin
                    status_next   = ST_UNREACHED;
                    distance_next = '0;
                end
                else
                begin
                    status_next   = ST_OK;
                    distance_next = dst_sat[OUT_DIST_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= '0;
            edge_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            edge_count_reg <= edge_count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        edge_idx_reg <= edge_idx_next;
        pass_reg     <= pass_next;
        op_reg       <= op_next;
        k1_reg       <= k1_next;
        k2_reg       <= k2_next;
        w_reg        <= w_next;
        f1_reg       <= f1_next;
        f2_reg       <= f2_next;
        i1_reg       <= i1_next;
        i2_reg       <= i2_next;
        status_reg   <= status_next;
        distance_reg <= distance_next;
    end

    // Node key memory
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[node_count_reg[NIW-1:0]] <= first_key;
        end
        key_rd_reg <= key_mem[scan_reg];
    end

    // Edge memories
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            efrom_mem[edge_count_reg[EIW-1:0]] <= i1_reg;
            eto_mem[edge_count_reg[EIW-1:0]]   <= i2_reg;
            ew_mem[edge_count_reg[EIW-1:0]]    <= w_reg;
        end
        efrom_rd_reg <= efrom_mem[edge_idx_reg];
        eto_rd_reg   <= eto_mem[edge_idx_reg];
        ew_rd_reg    <= ew_mem[edge_idx_reg];
    end

    // Distance memory: reached flag on top of the working distance
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_wa] <= dist_wd;
        end
        ds_rd_reg <= dist_mem[dist_ra];
        de_rd_reg <= dist_mem[eto_rd_reg];
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    a_node_cap: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg <= NCW'(MAX_NODES))
        else $error("node count beyond capacity");

    a_edge_cap: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= ECW'(MAX_EDGES))
        else $error("edge count beyond capacity");

    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op_t'(op) == OP_SOLVE) |=> busy)
        else $error("solve item did not raise busy");

    a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (distance_reg == '0))
        else $error("nonzero distance with error status");
`endif

endmodule

`default_nettype wire
